[src/bcm_pkg.sv]
package bcm_pkg;

  localparam int ENTRIES         = 16;
  localparam int DISKS           = 16;
  localparam int BLOCKS_PER_DISK = 256;
  localparam int BLOCK_WORDS     = 32;
  localparam int MIN_ENTRIES     = 2;

  localparam int SLOT_W   = $clog2(ENTRIES);
  localparam int NCNT_W   = $clog2(ENTRIES + 1);
  localparam int WIDX_W   = $clog2(BLOCK_WORDS);
  localparam int COPY_W   = $clog2(BLOCK_WORDS + 1);
  localparam int ADDR_W   = SLOT_W + WIDX_W;
  localparam int STAMP_W  = 32;
  localparam int DISK_W   = 4;
  localparam int BLK_W    = 8;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int OIDX_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_REJ   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTEN = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CACHE_ON = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES  = 2'd1;

  typedef struct packed {
    logic               clear;
    logic               tag_we;
    logic               stamp_we;
    logic [SLOT_W-1:0]  slot;
    logic [DISK_W-1:0]  disk;
    logic [BLK_W-1:0]   blk;
    logic [STAMP_W-1:0] stamp;
  } cell_cmd_t;

  typedef struct packed {
    logic               vld;
    logic               hit;
    logic [SLOT_W-1:0]  hit_idx;
    logic               empty;
    logic [SLOT_W-1:0]  empty_idx;
    logic [STAMP_W-1:0] best_stamp;
    logic [SLOT_W-1:0]  best_idx;
  } scan_tok_t;

endpackage

[src/bcm_if.sv]
interface bcm_in_if;
  import bcm_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [DISK_W-1:0]   disk;
  logic [BLK_W-1:0]    blk;
  logic [WIDX_W-1:0]   word_index;
  logic [63:0]         data_word;
  modport source (output valid, kind, disk, blk, word_index, data_word, input ready);
  modport sink (input valid, kind, disk, blk, word_index, data_word, output ready);
endinterface

interface bcm_out_if;
  import bcm_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [63:0]         out_word;
  logic [OIDX_W-1:0]   out_index;
  logic                last;
  logic [31:0]         hit_count;
  logic [31:0]         query_count;
  modport source (output valid, status, out_word, out_index, last, hit_count, query_count,
                  input ready);
  modport sink (input valid, status, out_word, out_index, last, hit_count, query_count,
                output ready);
endinterface

interface bcm_cfg_if;
  import bcm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/block_cache_mru_evict.sv]
// Fully associative cache of 16 disk blocks of 32 64-bit words with
// most-recently-used eviction. Tags and stamps sit in a row of 16 cells;
// every operation that needs a search sends a token down the row, one cell
// per cycle: the token is launched, then passes through each cell in turn.
// A lookup hit then streams the 32 block words, each through a registered
// data memory read and then the output register, and holds while the output
// is stalled. Insert and update on the last word copy the staged block into
// the data memory after the search (update on a hit, insert on a miss with a
// valid tag). One item is in progress at a time; the output register lets
// the next item in while a result waits.
module block_cache_mru_evict
  import bcm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  bcm_in_if.sink    in_ch,
  bcm_out_if.source out_ch,
  bcm_cfg_if.sink   cfg_ch
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_COPY, ST_STREAM, ST_RESP
  } state_t;

  typedef enum logic [1:0] {OP_LOOKUP, OP_INSERT, OP_UPDATE} op_t;

  state_t              state_r;
  op_t                 op_r;
  logic                cache_on_r;
  logic [NCNT_W-1:0]   eiu_r;
  logic [NCNT_W-1:0]   n_act;
  logic [STAMP_W-1:0]  clock_r;
  logic [31:0]         hits_r;
  logic [31:0]         queries_r;
  logic [DISK_W-1:0]   q_disk_r;
  logic [BLK_W-1:0]    q_blk_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [STATUS_W-1:0] stat_r;
  logic [COPY_W-1:0]   copy_k_r;
  logic [WIDX_W-1:0]   strm_k_r;
  logic                rd_pend_r;
  logic                scan_go;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [63:0]         out_word_r;
  logic [OIDX_W-1:0]   out_index_r;
  logic                out_last_r;
  logic [31:0]         out_hits_r;
  logic [31:0]         out_queries_r;

  logic [63:0] stg_mem [BLOCK_WORDS];
  logic [63:0] ent_mem [ENTRIES * BLOCK_WORDS];
  logic [63:0] stg_rdata_r;
  logic [63:0] ent_rdata_r;

  logic        in_acc;
  logic        cfg_acc;
  logic        out_free;
  logic        tag_bad;
  logic        create;
  cell_cmd_t   cmd;
  scan_tok_t   tok [ENTRIES + 1];
  scan_tok_t   tok_last;
  logic [ENTRIES-1:0] active;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign create = cfg_acc && cfg_ch.index == REG_CACHE_ON && cfg_ch.data[0] && !cache_on_r;

  assign n_act = (eiu_r < NCNT_W'(MIN_ENTRIES)) ? NCNT_W'(MIN_ENTRIES) :
                 (eiu_r > NCNT_W'(ENTRIES)) ? NCNT_W'(ENTRIES) : eiu_r;

  assign tag_bad = (32'(q_disk_r) >= 32'(DISKS)) || (32'(q_blk_r) >= 32'(BLOCKS_PER_DISK));

  assign tok[0] = '{vld: scan_go, default: '0};
  assign tok_last = tok[ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign active[i] = (NCNT_W'(i) < n_act);
    bcm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (SLOT_W'(i)),
      .active   (active[i]),
      .q_disk   (q_disk_r),
      .q_blk    (q_blk_r),
      .cmd      (cmd),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  always_comb begin
    cmd       = '0;
    cmd.clear = create;
    cmd.disk  = q_disk_r;
    cmd.blk   = q_blk_r;
    cmd.slot  = tok_last.hit_idx;
    cmd.stamp = clock_r + 32'd1;
    if (state_r == ST_SCAN && tok_last.vld) begin
      case (op_r)
        OP_LOOKUP, OP_UPDATE: begin
          cmd.stamp_we = tok_last.hit;
        end
        OP_INSERT: begin
          if (!tag_bad && !tok_last.hit) begin
            cmd.tag_we   = 1'b1;
            cmd.stamp_we = 1'b1;
            cmd.stamp    = clock_r;
            cmd.slot     = tok_last.empty ? tok_last.empty_idx : tok_last.best_idx;
          end
        end
        default: begin
          cmd.stamp_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && cache_on_r &&
        (in_ch.kind == KIND_INSERT || in_ch.kind == KIND_UPDATE))
      stg_mem[in_ch.word_index] <= in_ch.data_word;
    if (state_r == ST_COPY && copy_k_r < COPY_W'(BLOCK_WORDS))
      stg_rdata_r <= stg_mem[copy_k_r[WIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_COPY && copy_k_r != '0)
      ent_mem[{slot_r, WIDX_W'(copy_k_r - COPY_W'(1))}] <= stg_rdata_r;
    if (state_r == ST_STREAM && !rd_pend_r)
      ent_rdata_r <= ent_mem[{slot_r, strm_k_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_LOOKUP;
      cache_on_r  <= 1'b0;
      eiu_r       <= NCNT_W'(ENTRIES);
      clock_r     <= '0;
      hits_r      <= '0;
      queries_r   <= '0;
      scan_go     <= 1'b0;
      rd_pend_r   <= 1'b0;
      copy_k_r    <= '0;
      strm_k_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      scan_go <= 1'b0;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (cfg_acc) begin
        case (cfg_ch.index)
          REG_CACHE_ON: begin
            cache_on_r <= cfg_ch.data[0];
            if (create) begin
              clock_r   <= '0;
              hits_r    <= '0;
              queries_r <= '0;
            end
          end
          REG_ENTRIES: eiu_r <= cfg_ch.data;
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            q_disk_r <= in_ch.disk;
            q_blk_r  <= in_ch.blk;
            if (!cache_on_r) begin
              stat_r  <= STAT_NOTEN;
              state_r <= ST_RESP;
            end else if (in_ch.kind == KIND_LOOKUP) begin
              op_r    <= OP_LOOKUP;
              scan_go <= 1'b1;
              state_r <= ST_SCAN;
            end else if ((in_ch.kind != KIND_INSERT && in_ch.kind != KIND_UPDATE) ||
                         32'(in_ch.word_index) >= 32'(BLOCK_WORDS)) begin
              stat_r  <= STAT_REJ;
              state_r <= ST_RESP;
            end else if (32'(in_ch.word_index) != 32'(BLOCK_WORDS - 1)) begin
              stat_r  <= STAT_OK;
              state_r <= ST_RESP;
            end else begin
              op_r    <= (in_ch.kind == KIND_INSERT) ? OP_INSERT : OP_UPDATE;
              scan_go <= 1'b1;
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (tok_last.vld) begin
            slot_r   <= tok_last.hit_idx;
            copy_k_r <= '0;
            strm_k_r <= '0;
            case (op_r)
              OP_LOOKUP: begin
                queries_r <= queries_r + 32'd1;
                if (tok_last.hit) begin
                  hits_r  <= hits_r + 32'd1;
                  clock_r <= clock_r + 32'd1;
                  state_r <= ST_STREAM;
                end else begin
                  stat_r  <= STAT_MISS;
                  state_r <= ST_RESP;
                end
              end
              OP_UPDATE: begin
                if (tok_last.hit) begin
                  clock_r <= clock_r + 32'd1;
                  state_r <= ST_COPY;
                end else begin
                  stat_r  <= STAT_MISS;
                  state_r <= ST_RESP;
                end
              end
              default: begin
                if (tag_bad || tok_last.hit) begin
                  stat_r  <= STAT_REJ;
                  state_r <= ST_RESP;
                end else begin
                  slot_r  <= cmd.slot;
                  clock_r <= clock_r + 32'd1;
                  state_r <= ST_COPY;
                end
              end
            endcase
          end
        end
        ST_COPY: begin
          copy_k_r <= copy_k_r + COPY_W'(1);
          if (copy_k_r == COPY_W'(BLOCK_WORDS)) begin
            stat_r  <= STAT_OK;
            state_r <= ST_RESP;
          end
        end
        ST_STREAM: begin
          if (!rd_pend_r) begin
            rd_pend_r <= 1'b1;
          end else if (out_free) begin
            rd_pend_r     <= 1'b0;
            out_valid_r   <= 1'b1;
            out_status_r  <= STAT_OK;
            out_word_r    <= ent_rdata_r;
            out_index_r   <= OIDX_W'(strm_k_r);
            out_last_r    <= (32'(strm_k_r) == 32'(BLOCK_WORDS - 1));
            out_hits_r    <= hits_r;
            out_queries_r <= queries_r;
            strm_k_r      <= strm_k_r + WIDX_W'(1);
            if (32'(strm_k_r) == 32'(BLOCK_WORDS - 1)) state_r <= ST_IDLE;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= stat_r;
            out_word_r    <= '0;
            out_index_r   <= '0;
            out_last_r    <= 1'b1;
            out_hits_r    <= hits_r;
            out_queries_r <= queries_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.out_word    = out_word_r;
  assign out_ch.out_index   = out_index_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.hit_count   = out_hits_r;
  assign out_ch.query_count = out_queries_r;

`ifndef SYNTHESIS
  a_tok_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_last.vld |-> state_r == ST_SCAN) else $error("scan token outside search");
  a_tag_we_insert: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tag_we |-> op_r == OP_INSERT) else $error("tag write outside insert");
  a_hit_active: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_last.vld && tok_last.hit) |-> NCNT_W'(tok_last.hit_idx) < n_act)
    else $error("hit in inactive slot");
  a_copy_idle_in: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COPY |-> !in_ch.ready) else $error("input taken during copy");
`endif

endmodule

[src/bcm_cell.sv]
module bcm_cell
  import bcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] cell_idx,
  input  logic              active,
  input  logic [DISK_W-1:0] q_disk,
  input  logic [BLK_W-1:0]  q_blk,
  input  cell_cmd_t         cmd,
  input  scan_tok_t         tok_in,
  output scan_tok_t         tok_out
);

  logic               valid_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [DISK_W-1:0]  disk_r;
  logic [BLK_W-1:0]   blk_r;
  scan_tok_t          tok_r;
  scan_tok_t          tok_nxt;
  logic               sel;

  assign sel = (cmd.slot == cell_idx);

  always_comb begin
    tok_nxt = tok_in;
    if (active) begin
      if (valid_r && disk_r == q_disk && blk_r == q_blk && !tok_in.hit) begin
        tok_nxt.hit     = 1'b1;
        tok_nxt.hit_idx = cell_idx;
      end
      if (!valid_r && !tok_in.empty) begin
        tok_nxt.empty     = 1'b1;
        tok_nxt.empty_idx = cell_idx;
      end
      if (stamp_r > tok_in.best_stamp) begin
        tok_nxt.best_stamp = stamp_r;
        tok_nxt.best_idx   = cell_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      stamp_r <= '0;
      tok_r   <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (cmd.clear) begin
        valid_r <= 1'b0;
        stamp_r <= '0;
      end else begin
        if (cmd.tag_we && sel) valid_r <= 1'b1;
        if (cmd.stamp_we && sel) stamp_r <= cmd.stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tag_we && sel) begin
      disk_r <= cmd.disk;
      blk_r  <= cmd.blk;
    end
  end

  assign tok_out = tok_r;

endmodule

[test/tb_block_cache_mru_evict.sv]
module tb_block_cache_mru_evict;
  import bcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
  localparam int SETTLE_CYCLES = 60;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 250;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [63:0]         word;
    logic [OIDX_W-1:0]   index;
    logic                last;
    logic [31:0]         hits;
    logic [31:0]         queries;
  } cache_word_t;

  logic clk = 1'b0;
  logic rst_n;

  bcm_in_if  in_if();
  bcm_out_if out_if();
  bcm_cfg_if cfg_if();

  block_cache_mru_evict DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if), .cfg_ch(cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the cache
  logic              m_on = 1'b0;
  logic [4:0]        m_slots = 5'd16;
  bit                m_valid [ENTRIES];
  logic [3:0]        m_disk [ENTRIES];
  logic [7:0]        m_blk [ENTRIES];
  logic [31:0]       m_stamp [ENTRIES];
  logic [63:0]       m_data [ENTRIES][BLOCK_WORDS];
  logic [63:0]       m_stage [BLOCK_WORDS];
  logic [31:0]       m_clock = '0, m_hits = '0, m_queries = '0;

  cache_word_t expected_words[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit all_staged = 1'b0;
  int items_sent = 0;
  logic [3:0] pool_disk [8] = '{4'd0, 4'd15, 4'd5, 4'd10, 4'd3, 4'd12, 4'd0, 4'd9};
  logic [7:0] pool_blk [8] = '{8'd0, 8'd255, 8'hA5, 8'h5A, 8'h0F, 8'hF0, 8'd1, 8'h80};

  function automatic int active_slots();
    if (m_slots < MIN_ENTRIES) return MIN_ENTRIES;
    if (m_slots > ENTRIES) return ENTRIES;
    return m_slots;
  endfunction

  function automatic int find_entry(logic [3:0] d, logic [7:0] b);
    for (int i = 0; i < active_slots(); i++)
      if (m_valid[i] && m_disk[i] == d && m_blk[i] == b) return i;
    return -1;
  endfunction

  function automatic void push_word(logic [STATUS_W-1:0] st, logic [63:0] w,
                                    logic [OIDX_W-1:0] idx, logic lst);
    cache_word_t e;
    e.status = st; e.word = w; e.index = idx; e.last = lst;
    e.hits = m_hits; e.queries = m_queries;
    expected_words.push_back(e);
  endfunction

  function automatic void predict_cache(logic [KIND_W-1:0] k, logic [3:0] d, logic [7:0] b,
                                        logic [WIDX_W-1:0] wi, logic [63:0] dw);
    int s;
    int n;
    if (!m_on) begin
      push_word(STAT_NOTEN, '0, '0, 1'b1);
      return;
    end
    if (k == KIND_LOOKUP) begin
      m_queries++;
      s = find_entry(d, b);
      if (s < 0) begin
        push_word(STAT_MISS, '0, '0, 1'b1);
        return;
      end
      m_hits++;
      m_clock++;
      m_stamp[s] = m_clock;
      for (int i = 0; i < BLOCK_WORDS; i++)
        push_word(STAT_OK, m_data[s][i], i[OIDX_W-1:0], i == BLOCK_WORDS - 1);
      return;
    end
    if (k == KIND_UNKNOWN) begin
      push_word(STAT_REJ, '0, '0, 1'b1);
      return;
    end
    m_stage[wi] = dw;
    if (wi != BLOCK_WORDS - 1) begin
      push_word(STAT_OK, '0, '0, 1'b1);
      return;
    end
    s = find_entry(d, b);
    if (k == KIND_UPDATE) begin
      if (s < 0) begin
        push_word(STAT_MISS, '0, '0, 1'b1);
        return;
      end
      m_data[s] = m_stage;
      m_clock++;
      m_stamp[s] = m_clock;
      push_word(STAT_OK, '0, '0, 1'b1);
      return;
    end
    if (s >= 0) begin
      push_word(STAT_REJ, '0, '0, 1'b1);
      return;
    end
    n = active_slots();
    s = -1;
    for (int i = 0; i < n; i++)
      if (s < 0 && !m_valid[i]) s = i;
    if (s < 0) begin
      s = 0;
      for (int i = 1; i < n; i++)
        if (m_stamp[i] > m_stamp[s]) s = i;
    end
    m_valid[s] = 1'b1;
    m_disk[s] = d;
    m_blk[s] = b;
    m_data[s] = m_stage;
    m_stamp[s] = m_clock;
    m_clock++;
    push_word(STAT_OK, '0, '0, 1'b1);
  endfunction

  task automatic send_item(logic [KIND_W-1:0] k, logic [3:0] d, logic [7:0] b,
                           logic [WIDX_W-1:0] wi, logic [63:0] dw);
    in_if.valid <= 1'b1;
    in_if.kind <= k;
    in_if.disk <= d;
    in_if.blk <= b;
    in_if.word_index <= wi;
    in_if.data_word <= dw;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_cache(k, d, b, wi, dw);
    items_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    if (idx == REG_CACHE_ON) begin
      if (val[0] && !m_on) begin
        m_valid = '{default: 1'b0};
        m_stamp = '{default: '0};
        m_clock = '0; m_hits = '0; m_queries = '0;
      end
      m_on = val[0];
    end else if (idx == REG_ENTRIES) begin
      m_slots = val;
    end
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic write_block(logic [KIND_W-1:0] k, logic [3:0] d, logic [7:0] b, bit full);
    if (full) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++)
        send_item(k, d, b, i[WIDX_W-1:0], rand_word());
      all_staged = 1'b1;
    end else begin
      repeat ($urandom_range(0, 3))
        send_item(k, d, b, WIDX_W'($urandom_range(0, BLOCK_WORDS - 2)), rand_word());
    end
    send_item(k, d, b, WIDX_W'(BLOCK_WORDS - 1), rand_word());
  endtask

  task automatic run_traffic(int n_items);
    int stop;
    int r;
    int p;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      r = $urandom_range(0, 9);
      p = $urandom_range(0, 7);
      if (!all_staged || r < 2)
        write_block(KIND_INSERT, pool_disk[p], pool_blk[p], 1'b1);
      else if (r == 2)
        write_block(KIND_UPDATE, pool_disk[p], pool_blk[p], $urandom_range(0, 3) == 0);
      else if (r == 3)
        write_block(KIND_INSERT, pool_disk[p], pool_blk[p], 1'b0);
      else if (r < 9)
        send_item(KIND_LOOKUP, pool_disk[p], pool_blk[p], WIDX_W'($urandom),
                  {$urandom, $urandom});
      else
        send_item($urandom_range(0, 1) ? KIND_UNKNOWN : KIND_LOOKUP, 4'($urandom),
                  8'($urandom), WIDX_W'($urandom), {$urandom, $urandom});
    end
  endtask

  task automatic test_disabled();
    write_reg(REG_ENTRIES, 5'd31);
    write_reg(REG_CACHE_ON, 1'b0);
    send_item(KIND_LOOKUP, 4'd0, 8'd0, 5'd0, '0);
    send_item(KIND_INSERT, 4'd15, 8'd255, 5'd31, '1);
    send_item(KIND_UPDATE, 4'd15, 8'd255, 5'd31, '1);
    send_item(KIND_UNKNOWN, 4'd15, 8'd255, 5'd31, '1);
  endtask

  task automatic test_directed();
    write_reg(REG_CACHE_ON, 1'b1);
    send_item(KIND_LOOKUP, 4'd15, 8'd255, 5'd31, '1);
    send_item(KIND_LOOKUP, 4'd0, 8'd0, 5'd0, '0);
    send_item(KIND_UNKNOWN, 4'd15, 8'd255, 5'd31, '1);
    send_item(KIND_UNKNOWN, 4'd0, 8'd0, 5'd0, '0);
    send_item(KIND_UPDATE, 4'd15, 8'd255, 5'd0, '1);
    send_item(KIND_UPDATE, 4'd15, 8'd255, 5'd31, '1);
    send_item(KIND_INSERT, 4'd0, 8'd0, 5'd0, '0);
  endtask

  task automatic test_eviction_two_slots();
    write_reg(REG_ENTRIES, 5'd2);
    run_traffic(70);
    write_reg(REG_ENTRIES, 5'd0);
    run_traffic(30);
  endtask

  task automatic test_backpressure();
    write_reg(REG_ENTRIES, 5'd31);
    hold_req = 1'b1;
    run_traffic(70);
  endtask

  task automatic test_recreate();
    write_reg(REG_CACHE_ON, 1'b0);
    send_item(KIND_LOOKUP, pool_disk[0], pool_blk[0], 5'd0, '0);
    write_reg(REG_CACHE_ON, 1'b1);
    write_reg(REG_ENTRIES, 5'd16);
    quiet = 1'b1;
    run_traffic(60);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.kind <= KIND_LOOKUP;
    in_if.disk <= '0;
    in_if.blk <= '0;
    in_if.word_index <= '0;
    in_if.data_word <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_CACHE_ON;
    cfg_if.data <= '0;
    m_valid = '{default: 1'b0};
    m_stamp = '{default: '0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_disabled();
    test_directed();
    test_eviction_two_slots();
    test_backpressure();
    test_recreate();
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // result-side stall: random bursts, plus one long hold-off
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cache_word_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word status=%0d out_word=%h", $realtime,
                 out_if.status, out_if.out_word);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_if.status !== e.status || out_if.out_word !== e.word ||
            out_if.out_index !== e.index || out_if.last !== e.last ||
            out_if.hit_count !== e.hits || out_if.query_count !== e.queries) begin
          $display("%0t: expected st=%0d w=%h i=%0d l=%0d h=%0d q=%0d", $realtime,
                   e.status, e.word, e.index, e.last, e.hits, e.queries);
          $display("%0t: actual   st=%0d w=%h i=%0d l=%0d h=%0d q=%0d", $realtime,
                   out_if.status, out_if.out_word, out_if.out_index, out_if.last,
                   out_if.hit_count, out_if.query_count);
          errors++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[files.f]
src/bcm_pkg.sv
src/bcm_if.sv
src/bcm_cell.sv
src/block_cache_mru_evict.sv
test/tb_block_cache_mru_evict.sv
